[rtl/rbm_rr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes, limits and the sigmoid table of the rating reconstruct block.
package rbm_rr_pkg;

    localparam int MAX_VISIBLE_DEF = 256;
    localparam int MAX_CLASSES_DEF = 16;
    localparam int MAX_HIDDEN_DEF  = 32;
    localparam int VALUE_W         = 16;
    localparam int ACC_W           = 32;
    localparam int PROB_W          = 13;
    localparam int SIG_SIZE        = 256;

    localparam logic [1:0] CFG_VISIBLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_CLASS_COUNT   = 2'd1;
    localparam logic [1:0] CFG_HIDDEN_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        ACT_LOAD_WEIGHT = 3'd0,
        ACT_LOAD_VBIAS  = 3'd1,
        ACT_LOAD_HBIAS  = 3'd2,
        ACT_SET_RATING  = 3'd3,
        ACT_RECONSTRUCT = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_H_START,
        ST_H_LOAD,
        ST_V_WREAD,
        ST_V_ACC,
        ST_H_DONE,
        ST_C_START,
        ST_C_LOAD,
        ST_P_MUL,
        ST_P_ACC,
        ST_C_DONE,
        ST_OUT
    } t_state;

    typedef logic [PROB_W-1:0] t_sig_table [SIG_SIZE];

    // Restoring division, used only while the constant table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(j/16) in Q32, from a power series held in Q44.
    function automatic logic [63:0] exp_q32(input logic [63:0] j);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 44;
        sum  = term;
        for (int n = 1; n < 200; n++) begin
            if (term != 64'd0) begin
                term = udiv64(term * j, 64'(16 * n));
                sum  = sum + term;
            end
        end
        return sum >> 12;
    endfunction

    function automatic t_sig_table build_sig();
        t_sig_table tab;
        logic [63:0] f;
        logic [63:0] den;
        logic [63:0] num;
        for (int i = 0; i < SIG_SIZE; i++) begin
            if (i >= 128) begin
                f   = exp_q32(64'(i - 128));
                den = f + (64'd1 << 32);
                num = 64'd8192 * f + den;
            end else begin
                f   = exp_q32(64'(128 - i));
                den = f + (64'd1 << 32);
                num = (64'd1 << 45) + den;
            end
            tab[i] = PROB_W'(udiv64(num, den << 1));
        end
        return tab;
    endfunction

    localparam t_sig_table SIG_TABLE = build_sig();

endpackage

[rtl/rbm_rating_reconstruct_core.sv]
`timescale 1ns / 1ps
// Top level of the softmax RBM rating reconstruct block: stores, sequencer and shared adder.
//
// Load and set items are taken without going busy. A reconstruct item keeps busy high
// while it walks the hidden units over the visible units, then the classes over the
// hidden units, up to the clamped visible, hidden and class counts vc, hc and kc; the
// one registered read port of the weight store and the single saturating accumulator
// set its length. The result strobe o_valid follows in the next cycle and lasts one
// cycle; the receiver cannot stall it. A reconstruct item whose visible_index is not
// below visible_count returns its error result in the cycle after acceptance without
// going busy. After reset the block clears all MAX_VISIBLE entries of the rating store,
// one entry a cycle, with busy high; configuration writes are taken at any time.
module rbm_rating_reconstruct_core #(
    parameter int MAX_VISIBLE = rbm_rr_pkg::MAX_VISIBLE_DEF,
    parameter int MAX_CLASSES = rbm_rr_pkg::MAX_CLASSES_DEF,
    parameter int MAX_HIDDEN  = rbm_rr_pkg::MAX_HIDDEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_visible_index,
    input  logic [3:0]  i_class_index,
    input  logic [4:0]  i_hidden_index,
    input  logic signed [15:0] i_param_value,
    input  logic [4:0]  i_rating,
    output logic        o_valid,
    output logic [4:0]  o_predicted_rating,
    output logic        o_index_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int VW  = (MAX_VISIBLE > 1) ? $clog2(MAX_VISIBLE) : 1;
    localparam int CW  = $clog2(MAX_CLASSES);
    localparam int HW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int VCW = $clog2(MAX_VISIBLE + 1);
    localparam int HCW = $clog2(MAX_HIDDEN + 1);
    localparam int WD  = MAX_VISIBLE * MAX_CLASSES * MAX_HIDDEN;
    localparam int WA  = $clog2(WD);
    localparam int BD  = MAX_VISIBLE * MAX_CLASSES;
    localparam int BA  = $clog2(BD);
    localparam int VALW = rbm_rr_pkg::VALUE_W;
    localparam int ACCW = rbm_rr_pkg::ACC_W;
    localparam int PW   = rbm_rr_pkg::PROB_W;
    localparam int PRW  = PW + 1 + VALW;

    // Stores
    logic [VALW-1:0] w_mem  [WD];
    logic [VALW-1:0] vb_mem [BD];
    logic [VALW-1:0] hb_mem [MAX_HIDDEN];
    logic [4:0]      rt_mem [MAX_VISIBLE];
    logic [PW-1:0]   hp_mem [MAX_HIDDEN];

    rbm_rr_pkg::t_state r_state, n_state;
    logic [7:0]  r_vi, n_vi;
    logic [VW-1:0] r_v, n_v, r_clr, n_clr;
    logic [HW-1:0] r_h, n_h, h_rd;
    logic [CW-1:0] r_c, n_c, r_best_c, n_best_c;
    logic signed [ACCW-1:0] r_acc, n_acc, r_best, n_best, addend;
    logic signed [PRW-1:0] r_prod, n_prod;
    logic r_rok, n_rok;
    logic [8:0] r_cfg_vis;
    logic [4:0] r_cfg_cls;
    logic [5:0] r_cfg_hid;
    logic r_out_valid, n_out_valid, r_out_err, n_out_err;
    logic [4:0] r_out_rating, n_out_rating;

    logic [VALW-1:0] r_w_q, r_vb_q, r_hb_q;
    logic [4:0]      r_rt_q;
    logic [PW-1:0]   r_hp_q;

    logic [VCW-1:0] vc;
    logic [HCW-1:0] hc;
    logic [4:0]     kc;
    logic accept, v_last, h_last, c_last, in_range, rating_ok;
    logic [ACCW:0] sum_w;
    logic signed [ACCW-1:0] sat_sum;
    logic [ACCW:0] t_idx;
    logic [7:0] sig_idx;

    logic w_we, vb_we, hb_we, rt_we, hp_we;
    logic [WA-1:0] w_waddr, w_raddr;
    logic [BA-1:0] vb_waddr, vb_raddr;
    logic [HW-1:0] hb_waddr;
    logic [VW-1:0] rt_waddr, rt_raddr;
    logic [4:0]    rt_wdata;

    function automatic logic [WA-1:0] widx(input int v, input int c, input int h);
        return WA'((v * MAX_CLASSES + c) * MAX_HIDDEN + h);
    endfunction

    assign busy        = (r_state != rbm_rr_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_valid            = r_out_valid;
    assign o_predicted_rating = r_out_rating;
    assign o_index_error      = r_out_err;

    // Effective counts
    always_comb begin
        if (r_cfg_vis == 9'd0)                  vc = VCW'(1);
        else if (int'(r_cfg_vis) > MAX_VISIBLE) vc = VCW'(MAX_VISIBLE);
        else                                    vc = VCW'(r_cfg_vis);
        if (int'(r_cfg_hid) < 1)                hc = HCW'(1);
        else if (int'(r_cfg_hid) > MAX_HIDDEN)  hc = HCW'(MAX_HIDDEN);
        else                                    hc = HCW'(r_cfg_hid);
        if (int'(r_cfg_cls) < 2)                kc = 5'd2;
        else if (int'(r_cfg_cls) > MAX_CLASSES) kc = 5'(MAX_CLASSES);
        else                                    kc = r_cfg_cls;
    end

    assign in_range  = int'(i_visible_index) < int'(vc);
    assign v_last    = int'(r_v) == int'(vc) - 1;
    assign h_last    = int'(r_h) == int'(hc) - 1;
    assign c_last    = int'(r_c) == int'(kc) - 1;
    assign rating_ok = (r_rt_q != 5'd0) && (r_rt_q <= kc);
    assign h_rd      = (r_state == rbm_rr_pkg::ST_P_ACC) ? HW'(int'(r_h) + 1) : r_h;

    // Shared saturating accumulator
    always_comb begin
        if (r_state == rbm_rr_pkg::ST_P_ACC) begin
            addend = ACCW'(r_prod >>> 12);
        end else begin
            addend = ACCW'($signed(r_w_q));
        end
        sum_w = {r_acc[ACCW-1], r_acc} + {addend[ACCW-1], addend};
        if (sum_w[ACCW] != sum_w[ACCW-1]) begin
            sat_sum = sum_w[ACCW] ? {1'b1, {(ACCW-1){1'b0}}} : {1'b0, {(ACCW-1){1'b1}}};
        end else begin
            sat_sum = $signed(sum_w[ACCW-1:0]);
        end
    end

    // Sigmoid table index: floor((a + 32768) / 256), clipped to the table
    always_comb begin
        t_idx = {r_acc[ACCW-1], r_acc} + (ACCW+1)'(32768);
        if (t_idx[ACCW])           sig_idx = 8'd0;
        else if (|t_idx[ACCW-1:16]) sig_idx = 8'd255;
        else                        sig_idx = t_idx[15:8];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbm_rr_pkg::ST_IDLE: begin
                if (accept && i_action == rbm_rr_pkg::ACT_RECONSTRUCT && in_range) begin
                    n_state = rbm_rr_pkg::ST_H_START;
                end
            end
            rbm_rr_pkg::ST_CLEAR: begin
                if (int'(r_clr) == MAX_VISIBLE - 1) n_state = rbm_rr_pkg::ST_IDLE;
            end
            rbm_rr_pkg::ST_H_START: n_state = rbm_rr_pkg::ST_H_LOAD;
            rbm_rr_pkg::ST_H_LOAD:  n_state = rbm_rr_pkg::ST_V_WREAD;
            rbm_rr_pkg::ST_V_WREAD: n_state = rbm_rr_pkg::ST_V_ACC;
            rbm_rr_pkg::ST_V_ACC: begin
                n_state = v_last ? rbm_rr_pkg::ST_H_DONE : rbm_rr_pkg::ST_V_WREAD;
            end
            rbm_rr_pkg::ST_H_DONE: begin
                n_state = h_last ? rbm_rr_pkg::ST_C_START : rbm_rr_pkg::ST_H_START;
            end
            rbm_rr_pkg::ST_C_START: n_state = rbm_rr_pkg::ST_C_LOAD;
            rbm_rr_pkg::ST_C_LOAD:  n_state = rbm_rr_pkg::ST_P_MUL;
            rbm_rr_pkg::ST_P_MUL:   n_state = rbm_rr_pkg::ST_P_ACC;
            rbm_rr_pkg::ST_P_ACC: begin
                n_state = h_last ? rbm_rr_pkg::ST_C_DONE : rbm_rr_pkg::ST_P_MUL;
            end
            rbm_rr_pkg::ST_C_DONE: begin
                n_state = c_last ? rbm_rr_pkg::ST_OUT : rbm_rr_pkg::ST_C_START;
            end
            rbm_rr_pkg::ST_OUT: n_state = rbm_rr_pkg::ST_IDLE;
            default: n_state = rbm_rr_pkg::ST_IDLE;
        endcase
    end

    // Datapath, store controls and result
    always_comb begin
        n_vi = r_vi;  n_v = r_v;  n_h = r_h;  n_c = r_c;  n_clr = r_clr;
        n_acc = r_acc;  n_best = r_best;  n_best_c = r_best_c;
        n_prod = r_prod;  n_rok = r_rok;
        n_out_valid = 1'b0;  n_out_err = 1'b0;  n_out_rating = r_out_rating;
        w_we = 1'b0;  vb_we = 1'b0;  hb_we = 1'b0;  rt_we = 1'b0;  hp_we = 1'b0;
        w_waddr  = widx(int'(i_visible_index), int'(i_class_index), int'(i_hidden_index));
        vb_waddr = BA'(int'(i_visible_index) * MAX_CLASSES + int'(i_class_index));
        hb_waddr = HW'(i_hidden_index);
        rt_waddr = VW'(i_visible_index);
        rt_wdata = i_rating;
        if (r_state == rbm_rr_pkg::ST_V_WREAD) begin
            w_raddr = widx(int'(r_v), int'(r_rt_q) - 1, int'(r_h));
        end else begin
            w_raddr = widx(int'(r_vi), int'(r_c), int'(h_rd));
        end
        vb_raddr = BA'(int'(r_vi) * MAX_CLASSES + int'(r_c));
        rt_raddr = (r_state == rbm_rr_pkg::ST_V_ACC) ? VW'(int'(r_v) + 1) : r_v;

        unique case (r_state)
            rbm_rr_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        rbm_rr_pkg::ACT_LOAD_WEIGHT: begin
                            w_we = int'(i_visible_index) < MAX_VISIBLE
                                && int'(i_class_index) < MAX_CLASSES
                                && int'(i_hidden_index) < MAX_HIDDEN;
                        end
                        rbm_rr_pkg::ACT_LOAD_VBIAS: begin
                            vb_we = int'(i_visible_index) < MAX_VISIBLE
                                 && int'(i_class_index) < MAX_CLASSES;
                        end
                        rbm_rr_pkg::ACT_LOAD_HBIAS: begin
                            hb_we = int'(i_hidden_index) < MAX_HIDDEN;
                        end
                        rbm_rr_pkg::ACT_SET_RATING: begin
                            rt_we = in_range;
                        end
                        rbm_rr_pkg::ACT_RECONSTRUCT: begin
                            n_vi = i_visible_index;
                            n_h  = '0;
                            n_c  = '0;
                            if (!in_range) begin
                                n_out_valid  = 1'b1;
                                n_out_err    = 1'b1;
                                n_out_rating = 5'd0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            rbm_rr_pkg::ST_CLEAR: begin
                rt_we    = 1'b1;
                rt_waddr = r_clr;
                rt_wdata = 5'd0;
                n_clr    = VW'(int'(r_clr) + 1);
            end
            rbm_rr_pkg::ST_H_START: n_v = '0;
            rbm_rr_pkg::ST_H_LOAD:  n_acc = ACCW'($signed(r_hb_q));
            rbm_rr_pkg::ST_V_WREAD: n_rok = rating_ok;
            rbm_rr_pkg::ST_V_ACC: begin
                if (r_rok) n_acc = sat_sum;
                if (!v_last) n_v = VW'(int'(r_v) + 1);
            end
            rbm_rr_pkg::ST_H_DONE: begin
                hp_we = 1'b1;
                if (!h_last) n_h = HW'(int'(r_h) + 1);
            end
            rbm_rr_pkg::ST_C_START: n_h = '0;
            rbm_rr_pkg::ST_C_LOAD:  n_acc = ACCW'($signed(r_vb_q));
            rbm_rr_pkg::ST_P_MUL: begin
                n_prod = PRW'($signed({1'b0, r_hp_q}) * $signed(r_w_q));
            end
            rbm_rr_pkg::ST_P_ACC: begin
                n_acc = sat_sum;
                if (!h_last) n_h = HW'(int'(r_h) + 1);
            end
            rbm_rr_pkg::ST_C_DONE: begin
                // The first maximum wins, so only a strictly greater score replaces it.
                if (r_c == '0 || r_acc > r_best) begin
                    n_best   = r_acc;
                    n_best_c = r_c;
                end
                if (!c_last) n_c = CW'(int'(r_c) + 1);
            end
            rbm_rr_pkg::ST_OUT: begin
                n_out_valid  = 1'b1;
                n_out_rating = 5'(int'(r_best_c) + 1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbm_rr_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_out_err   <= 1'b0;
            r_cfg_vis   <= 9'd256;
            r_cfg_cls   <= 5'd5;
            r_cfg_hid   <= 6'd32;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_out_err   <= n_out_err;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rbm_rr_pkg::CFG_VISIBLE_COUNT: r_cfg_vis <= i_cfg_data;
                    rbm_rr_pkg::CFG_CLASS_COUNT:   r_cfg_cls <= i_cfg_data[4:0];
                    rbm_rr_pkg::CFG_HIDDEN_COUNT:  r_cfg_hid <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vi <= n_vi;  r_v <= n_v;  r_h <= n_h;  r_c <= n_c;
        r_acc <= n_acc;  r_best <= n_best;  r_best_c <= n_best_c;
        r_prod <= n_prod;  r_rok <= n_rok;  r_out_rating <= n_out_rating;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) w_mem[w_waddr] <= i_param_value;
        r_w_q <= w_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (vb_we) vb_mem[vb_waddr] <= i_param_value;
        r_vb_q <= vb_mem[vb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (hb_we) hb_mem[hb_waddr] <= i_param_value;
        r_hb_q <= hb_mem[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (rt_we) rt_mem[rt_waddr] <= rt_wdata;
        r_rt_q <= rt_mem[rt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (hp_we) hp_mem[r_h] <= rbm_rr_pkg::SIG_TABLE[sig_idx];
        r_hp_q <= hp_mem[h_rd];
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_error |-> o_predicted_rating == 5'd0)
        else $error("index error result carries a nonzero rating");

    a_rating_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_index_error |-> o_predicted_rating != 5'd0
            && int'(o_predicted_rating) <= MAX_CLASSES)
        else $error("predicted rating outside the class range");

    a_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_action == rbm_rr_pkg::ACT_RECONSTRUCT && in_range |=> busy)
        else $error("accepted reconstruct item did not start the sequencer");

    a_no_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rbm_rr_pkg::ST_H_START |-> !o_valid)
        else $error("result strobe while a reconstruct item is at work");

endmodule
